// ===== design/cbs_pkg.sv =====
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types, codes and constants for the converter bring-up sequencer.
// ----------------------------------------------------------------------------
package cbs_pkg;

  // Transaction codes on the input channel
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_FAULT = 2'd3
  } action_e;

  // Operating modes
  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_OPEN  = 3'd1,
    M_CDC   = 3'd2,
    M_OUTER = 3'd3,
    M_FAULT = 3'd4
  } mode_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_DC_CURRENT_REF = 3'd0,
    CFG_BUS_TARGET     = 3'd1,
    CFG_BUS_RAMP_RATE  = 3'd2,
    CFG_VOUT_REF       = 3'd3,
    CFG_PROP_GAIN      = 3'd4,
    CFG_INTEG_GAIN     = 3'd5,
    CFG_INTEG_LIMIT    = 3'd6,
    CFG_CURRENT_LIMIT  = 3'd7
  } cfg_idx_e;

  // Operand selection of the shared multiplier
  typedef enum logic [1:0] {
    MUL_STEP = 2'd0,  // ramp rate * dt
    MUL_EDT  = 2'd1,  // error * dt
    MUL_KI   = 2'd2,  // integ gain * (error * dt)
    MUL_KP   = 2'd3   // prop gain * error
  } mul_op_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_STEP  = 4'd1,
    ST_EXEC  = 4'd2,
    ST_EDT   = 4'd3,
    ST_KI    = 4'd4,
    ST_INTEG = 4'd5,
    ST_KP    = 4'd6,
    ST_SUM   = 4'd7,
    ST_DONE  = 4'd8
  } state_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Fixed design constants
  localparam logic signed [15:0] OL_DUTY_CMD    = 16'sd1638;
  localparam logic [14:0]        BUS_START      = 15'd3072;
  localparam logic [22:0]        BUS_START_FINE = {BUS_START, 8'd0};
  localparam logic [15:0]        OL_HOLD_MS     = 16'd200;
  localparam logic [15:0]        CDC_HOLD_MS    = 16'd300;
  localparam logic [7:0]         DT_MAX_MS      = 8'd100;

  // Configuration reset values
  localparam logic [14:0] RST_DC_CURRENT_REF = 15'd128;
  localparam logic [14:0] RST_BUS_TARGET     = 15'd6144;
  localparam logic [15:0] RST_BUS_RAMP_RATE  = 16'd262;
  localparam logic [14:0] RST_VOUT_REF       = 15'd2048;
  localparam logic [15:0] RST_PROP_GAIN      = 16'd205;
  localparam logic [15:0] RST_INTEG_GAIN     = 16'd524;
  localparam logic [14:0] RST_INTEG_LIMIT    = 15'd512;
  localparam logic [14:0] RST_CURRENT_LIMIT  = 15'd512;

  // Input transaction payload
  typedef struct packed {
    action_e            action;
    logic signed [15:0] vout_meas;
    logic               grid_lock;
    logic               hw_healthy;
    logic [7:0]         elapsed_ms;
  } in_item_t;

  // Output transaction payload
  typedef struct packed {
    logic [2:0]         mode;
    logic               ol_forced;
    logic               cur_loop_on;
    logic               vloop_on;
    logic signed [15:0] duty_cmd;
    logic signed [15:0] current_ref;
    logic [14:0]        bus_cmd;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    capture;
    logic    mul_en;
    mul_op_e mul_op;
    logic    exec;
    logic    integ_upd;
    logic    sum_upd;
    logic    out_load;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pi_req;
  } dp_status_t;

endpackage

// ===== design/cbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbs_ctrl
// Sequencing state machine: steps each transaction through the datapath and
// owns the input ready and output valid handshakes.
// ----------------------------------------------------------------------------
module cbs_ctrl
  import cbs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   load;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_STEP;
      ST_STEP:  state_d = ST_EXEC;
      ST_EXEC:  state_d = status_i.pi_req ? ST_EDT : ST_DONE;
      ST_EDT:   state_d = ST_KI;
      ST_KI:    state_d = ST_INTEG;
      ST_INTEG: state_d = ST_KP;
      ST_KP:    state_d = ST_SUM;
      ST_SUM:   state_d = ST_DONE;
      ST_DONE:  if (load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Output register may be loaded when empty or being drained
  assign load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // Commands
  always_comb begin
    cmd_o = '0;
    cmd_o.mul_op = MUL_STEP;
    case (state_q)
      ST_IDLE: cmd_o.capture = in_valid_i;
      ST_STEP: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_STEP;
      end
      ST_EXEC: cmd_o.exec = 1'b1;
      ST_EDT: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_EDT;
      end
      ST_KI: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_KI;
      end
      ST_INTEG: cmd_o.integ_upd = 1'b1;
      ST_KP: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_KP;
      end
      ST_SUM:  cmd_o.sum_upd = 1'b1;
      ST_DONE: cmd_o.out_load = load;
      default: cmd_o = '0;
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== design/cbs_datapath.sv =====
// ----------------------------------------------------------------------------
// cbs_datapath
// Configuration registers, sequencer state, bus ramp, shared multiplier and
// the PI outer loop arithmetic, plus the output register.
// ----------------------------------------------------------------------------
module cbs_datapath
  import cbs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_item_t              in_data_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            status_o,
  output out_item_t             out_data_o
);

  // Configuration
  logic [14:0] dc_current_ref_q, bus_target_q, vout_ref_q, integ_limit_q, current_limit_q;
  logic [15:0] bus_ramp_rate_q, prop_gain_q, integ_gain_q;

  // Captured transaction
  action_e            action_q;
  logic signed [15:0] vmeas_q;
  logic               locked_q;
  logic               hw_ok_q;
  logic [6:0]         dt_q;
  logic [6:0]         dt_norm;

  // Sequencer state
  mode_e              mode_q, mode_d;
  logic               start_q, start_d;
  logic [15:0]        time_q, time_d;
  logic [22:0]        bus_q, bus_d;
  logic signed [35:0] integ_q, integ_d;
  logic signed [15:0] cref_q, cref_d;
  logic signed [15:0] duty_q, duty_d;
  logic [2:0]         en_q, en_d;  // {outer, current, open}

  // Arithmetic
  logic signed [17:0] err_q, err_d;
  logic signed [16:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [42:0] prod_q, prod_d;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_current_ref_q <= RST_DC_CURRENT_REF;
      bus_target_q     <= RST_BUS_TARGET;
      bus_ramp_rate_q  <= RST_BUS_RAMP_RATE;
      vout_ref_q       <= RST_VOUT_REF;
      prop_gain_q      <= RST_PROP_GAIN;
      integ_gain_q     <= RST_INTEG_GAIN;
      integ_limit_q    <= RST_INTEG_LIMIT;
      current_limit_q  <= RST_CURRENT_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DC_CURRENT_REF: dc_current_ref_q <= cfg_data_i[14:0];
        CFG_BUS_TARGET:     bus_target_q     <= cfg_data_i[14:0];
        CFG_BUS_RAMP_RATE:  bus_ramp_rate_q  <= cfg_data_i;
        CFG_VOUT_REF:       vout_ref_q       <= cfg_data_i[14:0];
        CFG_PROP_GAIN:      prop_gain_q      <= cfg_data_i;
        CFG_INTEG_GAIN:     integ_gain_q     <= cfg_data_i;
        CFG_INTEG_LIMIT:    integ_limit_q    <= cfg_data_i[14:0];
        CFG_CURRENT_LIMIT:  current_limit_q  <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Replace a bad tick length by one millisecond
  assign dt_norm = (in_data_i.elapsed_ms == 8'd0 || in_data_i.elapsed_ms > DT_MAX_MS)
                   ? 7'd1 : in_data_i.elapsed_ms[6:0];

  // Capture the transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= in_data_i.action;
      vmeas_q  <= in_data_i.vout_meas;
      locked_q <= in_data_i.grid_lock;
      hw_ok_q  <= in_data_i.hw_healthy;
      dt_q     <= dt_norm;
    end
  end

  // Voltage error, registered with the ramp step
  assign err_d = $signed({3'b000, vout_ref_q}) - $signed({{2{vmeas_q[15]}}, vmeas_q});

  // Shared multiplier operands
  always_comb begin
    case (cmd_i.mul_op)
      MUL_STEP: begin
        mul_a = $signed({1'b0, bus_ramp_rate_q});
        mul_b = $signed({19'd0, dt_q});
      end
      MUL_EDT: begin
        mul_a = $signed({10'd0, dt_q});
        mul_b = {{8{err_q[17]}}, err_q};
      end
      MUL_KI: begin
        mul_a = $signed({1'b0, integ_gain_q});
        mul_b = prod_q[25:0];
      end
      MUL_KP: begin
        mul_a = $signed({1'b0, prop_gain_q});
        mul_b = {{8{err_q[17]}}, err_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = 43'(mul_a) * 43'(mul_b);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.mul_en && cmd_i.mul_op == MUL_STEP) begin
      err_q <= err_d;
    end
  end

  // Bus ramp toward target by the registered step
  logic [22:0]        tgt_fine;
  logic signed [24:0] ramp_err, ramp_step;
  logic [22:0]        bus_ramp;

  assign tgt_fine  = {bus_target_q, 8'd0};
  assign ramp_err  = $signed({2'b00, tgt_fine}) - $signed({2'b00, bus_q});
  assign ramp_step = $signed({2'b00, prod_q[22:0]});

  always_comb begin
    if (ramp_err > ramp_step) begin
      bus_ramp = bus_q + prod_q[22:0];
    end else if (ramp_err < -ramp_step) begin
      bus_ramp = bus_q - prod_q[22:0];
    end else begin
      bus_ramp = tgt_fine;
    end
  end

  // Mode time with saturation
  logic [16:0] time_sum;
  logic [15:0] time_sat;

  assign time_sum = {1'b0, time_q} + {10'd0, dt_q};
  assign time_sat = time_sum[16] ? 16'hFFFF : time_sum[15:0];

  // PI runs on a healthy, started, locked tick in outer mode
  assign status_o.pi_req = (action_q == ACT_TICK) && hw_ok_q && start_q &&
                           (mode_q == M_OUTER) && locked_q;

  // Integrator accumulate and clamp
  logic signed [43:0] integ_sum, integ_lim, integ_clamp;

  assign integ_sum = {{8{integ_q[35]}}, integ_q} + {prod_q[42], prod_q};
  assign integ_lim = $signed({9'd0, integ_limit_q, 20'd0});

  always_comb begin
    if (integ_sum > integ_lim) begin
      integ_clamp = integ_lim;
    end else if (integ_sum < -integ_lim) begin
      integ_clamp = -integ_lim;
    end else begin
      integ_clamp = integ_sum;
    end
  end

  // Proportional plus integral, clamp, round to 1/256 A
  logic signed [43:0] pi_sum, cur_lim, pi_clamp, pi_round;

  assign pi_sum  = $signed({prod_q[35:0], 8'd0}) + {{8{integ_q[35]}}, integ_q};
  assign cur_lim = $signed({9'd0, current_limit_q, 20'd0});

  always_comb begin
    if (pi_sum > cur_lim) begin
      pi_clamp = cur_lim;
    end else if (pi_sum < -cur_lim) begin
      pi_clamp = -cur_lim;
    end else begin
      pi_clamp = pi_sum;
    end
  end

  assign pi_round = pi_clamp + 44'sd524288;

  // Sequencer update
  mode_e       eff_mode;
  logic [15:0] eff_time;

  always_comb begin
    mode_d   = mode_q;
    start_d  = start_q;
    time_d   = time_q;
    bus_d    = bus_q;
    integ_d  = integ_q;
    cref_d   = cref_q;
    duty_d   = duty_q;
    en_d     = en_q;
    eff_mode = mode_q;
    eff_time = time_sat;

    if (cmd_i.exec) begin
      case (action_q)
        ACT_TICK: begin
          if (!hw_ok_q) begin
            // Hardware fault: enter fault, keep bus and integrator
            mode_d  = M_FAULT;
            en_d    = 3'b000;
            cref_d  = '0;
            duty_d  = '0;
            start_d = 1'b0;
          end else if (!start_q) begin
            // Not started: stop any running mode
            if (mode_q != M_IDLE && mode_q != M_FAULT) begin
              start_d = 1'b0;
              mode_d  = M_IDLE;
              en_d    = 3'b000;
              cref_d  = '0;
              duty_d  = '0;
              integ_d = '0;
              bus_d   = BUS_START_FINE;
              time_d  = '0;
            end
          end else if (mode_q != M_FAULT) begin
            // Active tick: ramp, then advance the mode
            if (mode_q == M_IDLE) begin
              eff_mode = M_OPEN;
              eff_time = '0;
              bus_d    = BUS_START_FINE;
            end else begin
              bus_d    = bus_ramp;
            end
            mode_d = eff_mode;
            time_d = eff_time;
            case (eff_mode)
              M_OPEN: begin
                en_d   = 3'b001;
                duty_d = OL_DUTY_CMD;
                cref_d = '0;
                if (locked_q && eff_time >= OL_HOLD_MS) begin
                  mode_d = M_CDC;
                  time_d = '0;
                end
              end
              M_CDC: begin
                en_d   = 3'b010;
                duty_d = '0;
                cref_d = $signed({1'b0, dc_current_ref_q});
                if (!locked_q) begin
                  mode_d = M_OPEN;
                  time_d = '0;
                end else if (eff_time >= CDC_HOLD_MS) begin
                  mode_d = M_OUTER;
                  time_d = '0;
                end
              end
              M_OUTER: begin
                en_d   = 3'b110;
                duty_d = '0;
                if (!locked_q) begin
                  mode_d = M_OPEN;
                  time_d = '0;
                end
              end
              default: ;
            endcase
          end
        end
        ACT_START: start_d = 1'b1;
        ACT_STOP: begin
          start_d = 1'b0;
          mode_d  = M_IDLE;
          en_d    = 3'b000;
          cref_d  = '0;
          duty_d  = '0;
          integ_d = '0;
          bus_d   = BUS_START_FINE;
          time_d  = '0;
        end
        ACT_FAULT: begin
          mode_d  = M_FAULT;
          en_d    = 3'b000;
          cref_d  = '0;
          duty_d  = '0;
          start_d = 1'b0;
        end
        default: ;
      endcase
    end

    if (cmd_i.integ_upd) begin
      integ_d = integ_clamp[35:0];
    end
    if (cmd_i.sum_upd) begin
      cref_d = pi_round[35:20];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      start_q <= 1'b0;
      time_q  <= '0;
      bus_q   <= BUS_START_FINE;
      integ_q <= '0;
      cref_q  <= '0;
      duty_q  <= '0;
      en_q    <= 3'b000;
    end else begin
      mode_q  <= mode_d;
      start_q <= start_d;
      time_q  <= time_d;
      bus_q   <= bus_d;
      integ_q <= integ_d;
      cref_q  <= cref_d;
      duty_q  <= duty_d;
      en_q    <= en_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_o.mode        <= mode_q;
      out_data_o.ol_forced   <= en_q[0];
      out_data_o.cur_loop_on <= en_q[1];
      out_data_o.vloop_on    <= en_q[2];
      out_data_o.duty_cmd    <= duty_q;
      out_data_o.current_ref <= cref_q;
      out_data_o.bus_cmd     <= bus_q[22:8];
    end
  end

endmodule

// ===== design/converter_bringup_sequencer_unit.sv =====
// A transaction is captured in IDLE and passes the STEP and EXEC states, plus
// EDT, KI, INTEG, KP and SUM for a locked tick in outer mode (PI update); DONE
// loads the output register when free, before the next is taken; the PI path is
// four passes through the one shared 17x26 multiplier plus clamp stages.
// Reset (async, active low): idle mode, bus at start value, configuration at
// defaults, output channel empty. No clearing pass.
// ----------------------------------------------------------------------------
// converter_bringup_sequencer_unit
// Start-up sequencer for a grid power converter: mode stepping with dwell
// times, bus command ramp and PI outer voltage loop.
// ----------------------------------------------------------------------------
module converter_bringup_sequencer_unit
  import cbs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  cbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cbs_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

// ===== design/cbs_checker.sv =====
// ----------------------------------------------------------------------------
// cbs_checker
// Port-level checks for the bring-up sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module cbs_checker
  import cbs_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  // One transaction in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while busy");

  // Fault mode drives nothing
  a_fault_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.mode == M_FAULT |->
      !out_data_o.ol_forced && !out_data_o.cur_loop_on &&
      !out_data_o.vloop_on && out_data_o.duty_cmd == 16'sd0 &&
      out_data_o.current_ref == 16'sd0)
    else $error("fault mode with active outputs");

  // Idle mode drives nothing
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.mode == M_IDLE |->
      !out_data_o.ol_forced && !out_data_o.cur_loop_on &&
      !out_data_o.vloop_on && out_data_o.duty_cmd == 16'sd0 &&
      out_data_o.current_ref == 16'sd0)
    else $error("idle mode with active outputs");

endmodule

bind converter_bringup_sequencer_unit cbs_checker u_cbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the converter bring-up sequencer. A behavioral
// predictor mirrors the mode machine, bus ramp and PI outer loop. A queued
// driver and a checking monitor run through several register settings and
// handshake pressure patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import cbs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned ITEMS_PHASE  = 258;
  localparam longint      LIMIT_NS     = 5_000_000;

  // Clock, reset and DUT connections
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  cfg_idx_e              cfg_idx = CFG_DC_CURRENT_REF;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;

  // Traffic shaping
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_left = 0;
  logic        hold_arm = 1'b0;

  // Transaction queues and error count
  in_item_t    pending_actions_q[$];
  out_item_t   expected_status_q[$];
  int unsigned fail_count = 0;

  // Mirrored configuration
  longint k_dc_ref       = RST_DC_CURRENT_REF;
  longint k_bus_target   = RST_BUS_TARGET;
  longint k_ramp_rate    = RST_BUS_RAMP_RATE;
  longint k_vout_ref     = RST_VOUT_REF;
  longint k_prop_gain    = RST_PROP_GAIN;
  longint k_integ_gain   = RST_INTEG_GAIN;
  longint k_integ_limit  = RST_INTEG_LIMIT;
  longint k_current_limit = RST_CURRENT_LIMIT;

  // Mirrored sequencer state
  mode_e       st_mode = M_IDLE;
  bit          st_start = 1'b0;
  int unsigned st_time = 0;
  longint      st_bus_fine = longint'(BUS_START) * 256;
  longint      st_integ = 0;
  int          st_iref = 0;
  int          st_duty = 0;
  bit          st_open = 1'b0;
  bit          st_cur = 1'b0;
  bit          st_outer = 1'b0;

  converter_bringup_sequencer_unit uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint clamp_sym(longint v, longint lim);
    if (v < -lim) return -lim;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic void enter_mode(mode_e m);
    st_mode = m;
    st_time = 0;
  endfunction

  function automatic void clear_to_idle();
    st_start = 1'b0;
    st_mode = M_IDLE;
    {st_open, st_cur, st_outer} = '0;
    st_iref = 0;
    st_duty = 0;
    st_integ = 0;
    st_bus_fine = longint'(BUS_START) * 256;
    st_time = 0;
  endfunction

  function automatic void trip_fault();
    st_mode = M_FAULT;
    {st_open, st_cur, st_outer} = '0;
    st_iref = 0;
    st_duty = 0;
    st_start = 1'b0;
  endfunction

  function automatic void mirror_cfg(cfg_idx_e idx, logic [15:0] v);
    case (idx)
      CFG_DC_CURRENT_REF: k_dc_ref = v[14:0];
      CFG_BUS_TARGET:     k_bus_target = v[14:0];
      CFG_BUS_RAMP_RATE:  k_ramp_rate = v;
      CFG_VOUT_REF:       k_vout_ref = v[14:0];
      CFG_PROP_GAIN:      k_prop_gain = v;
      CFG_INTEG_GAIN:     k_integ_gain = v;
      CFG_INTEG_LIMIT:    k_integ_limit = v[14:0];
      default:            k_current_limit = v[14:0];
    endcase
  endfunction

  // Advance the mode machine, ramp and outer loop by one tick
  function automatic void tick_sequencer(in_item_t it);
    longint      vm, e, step, tgt, gap, sum;
    int unsigned dt;
    vm = longint'($signed(it.vout_meas));
    dt = it.elapsed_ms;
    if (dt == 0 || dt > DT_MAX_MS) dt = 1;

    if (!it.hw_healthy) begin
      trip_fault();
      return;
    end
    if (!st_start) begin
      if (st_mode != M_IDLE && st_mode != M_FAULT) clear_to_idle();
      return;
    end
    if (st_mode == M_FAULT) return;

    st_time = (st_time + dt > 65535) ? 65535 : st_time + dt;

    // Ramp the bus command, landing exactly on the target
    step = k_ramp_rate * longint'(dt);
    tgt = k_bus_target * 256;
    gap = tgt - st_bus_fine;
    if (gap > step) st_bus_fine += step;
    else if (gap < -step) st_bus_fine -= step;
    else st_bus_fine = tgt;

    if (st_mode == M_IDLE) begin
      st_bus_fine = longint'(BUS_START) * 256;
      enter_mode(M_OPEN);
    end

    case (st_mode)
      M_OPEN: begin
        {st_open, st_cur, st_outer} = 3'b100;
        st_duty = OL_DUTY_CMD;
        st_iref = 0;
        if (it.grid_lock && st_time >= OL_HOLD_MS) enter_mode(M_CDC);
      end
      M_CDC: begin
        {st_open, st_cur, st_outer} = 3'b010;
        st_duty = 0;
        st_iref = int'(k_dc_ref);
        if (!it.grid_lock) enter_mode(M_OPEN);
        else if (st_time >= CDC_HOLD_MS) enter_mode(M_OUTER);
      end
      M_OUTER: begin
        {st_open, st_cur, st_outer} = 3'b011;
        st_duty = 0;
        if (!it.grid_lock) begin
          enter_mode(M_OPEN);
        end else begin
          e = k_vout_ref - vm;
          st_integ = clamp_sym(st_integ + k_integ_gain * e * longint'(dt),
                               k_integ_limit << 20);
          sum = clamp_sym(k_prop_gain * e * 256 + st_integ, k_current_limit << 20);
          st_iref = int'((sum + 524288) >>> 20);
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Apply one action and return the status the block must report
  function automatic out_item_t step_sequencer(in_item_t it);
    out_item_t res;
    case (it.action)
      ACT_TICK:  tick_sequencer(it);
      ACT_START: st_start = 1'b1;
      ACT_STOP:  clear_to_idle();
      default:   trip_fault();
    endcase
    res.mode = st_mode;
    res.ol_forced = st_open;
    res.cur_loop_on = st_cur;
    res.vloop_on = st_outer;
    res.duty_cmd = st_duty[15:0];
    res.current_ref = st_iref[15:0];
    res.bus_cmd = st_bus_fine[22:8];
    return res;
  endfunction

  // ------------------------------------------------------ driver and monitor

  // Drive the next pending action, holding each one until it is taken
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_status_q.push_back(step_sequencer(in_data));
      if (!in_valid || in_ready) begin
        if (pending_actions_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_actions_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      fail_count++;
      $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Check each accepted status transaction against the oldest prediction
  always @(posedge clk or negedge rst_n) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_status_q.size() == 0) begin
          fail_count++;
          $display("%0t unexpected transaction: expected none, actual %h", $time, out_data);
        end else begin
          want = expected_status_q.pop_front();
          check_field("mode", want.mode, out_data.mode);
          check_field("ol_forced", want.ol_forced, out_data.ol_forced);
          check_field("cur_loop_on", want.cur_loop_on, out_data.cur_loop_on);
          check_field("vloop_on", want.vloop_on, out_data.vloop_on);
          check_field("duty_cmd", $signed(want.duty_cmd), $signed(out_data.duty_cmd));
          check_field("current_ref", $signed(want.current_ref),
                      $signed(out_data.current_ref));
          check_field("bus_cmd", want.bus_cmd, out_data.bus_cmd);
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Count down a long receiver hold-off once armed
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_arm) hold_left <= HOLD_CYCLES;
  end

  // ---------------------------------------------------------------- stimulus

  function automatic in_item_t make_action(action_e a, int vm, bit lock, bit hw, int dt);
    in_item_t it;
    it.action = a;
    it.vout_meas = vm[15:0];
    it.grid_lock = lock;
    it.hw_healthy = hw;
    it.elapsed_ms = dt[7:0];
    return it;
  endfunction

  // Mostly healthy ticks near the setpoint, with rare disruptions
  function automatic in_item_t random_action(bit noise);
    in_item_t    it;
    int unsigned r;
    int          v;
    r = $urandom_range(99);
    if (noise) it.action = action_e'($urandom_range(3));
    else if (r < 2) it.action = ACT_START;
    else if (r < 4) it.action = ACT_STOP;
    else if (r < 5) it.action = ACT_FAULT;
    else it.action = ACT_TICK;
    if (noise || $urandom_range(1) == 0) begin
      it.vout_meas = 16'($urandom_range(65535));
    end else begin
      v = int'(k_vout_ref) + int'($urandom_range(800)) - 400;
      it.vout_meas = v[15:0];
    end
    it.grid_lock = noise ? 1'($urandom_range(1)) : ($urandom_range(99) < 94);
    it.hw_healthy = noise ? 1'($urandom_range(1)) : ($urandom_range(149) != 0);
    it.elapsed_ms = (noise || $urandom_range(7) == 0) ? 8'($urandom_range(255))
                                                      : 8'($urandom_range(100, 1));
    return it;
  endfunction

  // Queue start-up bursts, with some pure noise in between
  task automatic queue_bursts(int unsigned n_items);
    int unsigned count, len;
    count = 0;
    while (count < n_items) begin
      if ($urandom_range(9) == 0) begin
        len = $urandom_range(5, 1);
        repeat (len) pending_actions_q.push_back(random_action(1'b1));
      end else begin
        len = $urandom_range(50, 10);
        pending_actions_q.push_back(make_action(ACT_START, 0, 1'b1, 1'b1, 1));
        repeat (len) pending_actions_q.push_back(random_action(1'b0));
        len++;
      end
      count += len;
    end
  endtask

  task automatic queue_directed();
    // tick and stop while idle, then start
    pending_actions_q.push_back(make_action(ACT_TICK, 2048, 1'b1, 1'b1, 10));
    pending_actions_q.push_back(make_action(ACT_STOP, 0, 1'b0, 1'b1, 0));
    pending_actions_q.push_back(make_action(ACT_START, 0, 1'b0, 1'b1, 0));
    // zero and oversized tick lengths count as one ms
    pending_actions_q.push_back(make_action(ACT_TICK, 0, 1'b1, 1'b1, 0));
    pending_actions_q.push_back(make_action(ACT_TICK, 0, 1'b0, 1'b1, 255));
    pending_actions_q.push_back(make_action(ACT_TICK, 0, 1'b1, 1'b1, 100));
    pending_actions_q.push_back(make_action(ACT_TICK, 0, 1'b1, 1'b1, 100));
    // lock loss in current dc
    pending_actions_q.push_back(make_action(ACT_TICK, 0, 1'b0, 1'b1, 101));
    repeat (2) pending_actions_q.push_back(make_action(ACT_TICK, 0, 1'b1, 1'b1, 100));
    repeat (3) pending_actions_q.push_back(make_action(ACT_TICK, 0, 1'b1, 1'b1, 100));
    // outer loop at the voltage extremes and at zero error
    pending_actions_q.push_back(make_action(ACT_TICK, -32768, 1'b1, 1'b1, 100));
    pending_actions_q.push_back(make_action(ACT_TICK, 32767, 1'b1, 1'b1, 100));
    pending_actions_q.push_back(make_action(ACT_TICK, 2048, 1'b1, 1'b1, 1));
    // lock loss in outer, a repeated start, then fault handling
    pending_actions_q.push_back(make_action(ACT_TICK, 1000, 1'b0, 1'b1, 50));
    pending_actions_q.push_back(make_action(ACT_START, 0, 1'b0, 1'b1, 0));
    pending_actions_q.push_back(make_action(ACT_FAULT, 0, 1'b0, 1'b1, 0));
    pending_actions_q.push_back(make_action(ACT_TICK, 0, 1'b1, 1'b1, 20));
    pending_actions_q.push_back(make_action(ACT_START, 0, 1'b0, 1'b1, 0));
    pending_actions_q.push_back(make_action(ACT_TICK, 0, 1'b1, 1'b1, 20));
    pending_actions_q.push_back(make_action(ACT_STOP, 0, 1'b0, 1'b1, 0));
    // hardware not ok on a tick
    pending_actions_q.push_back(make_action(ACT_START, 0, 1'b0, 1'b1, 0));
    pending_actions_q.push_back(make_action(ACT_TICK, 0, 1'b1, 1'b1, 5));
    pending_actions_q.push_back(make_action(ACT_TICK, 0, 1'b1, 1'b0, 5));
    pending_actions_q.push_back(make_action(ACT_STOP, 0, 1'b0, 1'b1, 0));
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    mirror_cfg(idx, v);
  endtask

  task automatic program_all(logic [15:0] dc, logic [15:0] tgt, logic [15:0] rate,
                             logic [15:0] vref, logic [15:0] kp, logic [15:0] ki,
                             logic [15:0] ilim, logic [15:0] clim);
    write_reg(CFG_DC_CURRENT_REF, dc);
    write_reg(CFG_BUS_TARGET, tgt);
    write_reg(CFG_BUS_RAMP_RATE, rate);
    write_reg(CFG_VOUT_REF, vref);
    write_reg(CFG_PROP_GAIN, kp);
    write_reg(CFG_INTEG_GAIN, ki);
    write_reg(CFG_INTEG_LIMIT, ilim);
    write_reg(CFG_CURRENT_LIMIT, clim);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(int unsigned src, int unsigned snk);
    @(posedge clk);
    src_idle_pct <= src;
    snk_stall_pct <= snk;
  endtask

  // Hold off new traffic until every predicted status has arrived
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_actions_q.size() != 0 || in_valid || expected_status_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset configuration, no idling, with one long receiver hold-off
    queue_directed();
    queue_bursts(ITEMS_PHASE - 25);
    repeat (60) @(posedge clk);
    hold_arm <= 1'b1;
    @(posedge clk);
    hold_arm <= 1'b0;
    wait_drained();

    // Every register at its maximum, sender idling
    program_all(16'd32767, 16'd32767, 16'd65535, 16'd32767,
                16'd65535, 16'd65535, 16'd32767, 16'd32767);
    set_idling(65, 0);
    queue_bursts(ITEMS_PHASE);
    wait_drained();

    // Every register at zero, receiver stalling
    program_all('0, '0, '0, '0, '0, '0, '0, '0);
    set_idling(0, 65);
    queue_bursts(ITEMS_PHASE);
    wait_drained();

    // Random settings under mixed pressure
    for (int p = 0; p < 3; p++) begin
      if (p == 1)
        program_all(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                    16'($urandom_range(65535)), 16'($urandom_range(65535)),
                    16'($urandom_range(65535)), 16'($urandom_range(65535)),
                    16'($urandom_range(65535)), 16'($urandom_range(65535)));
      else
        program_all(16'($urandom_range(32767)), 16'($urandom_range(32767, 3072)),
                    16'($urandom_range(4000, 1)), 16'($urandom_range(32767)),
                    16'($urandom_range(65535)), 16'($urandom_range(65535)),
                    16'($urandom_range(32767)), 16'($urandom_range(32767, 1)));
      case (p)
        0:       set_idling(37, 37);
        1:       set_idling(0, 0);
        default: set_idling(65, 37);
      endcase
      queue_bursts(ITEMS_PHASE);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("[converter_bringup_sequencer_unit] OK");
    end else begin
      $display("[converter_bringup_sequencer_unit] ERROR");
    end
    $finish;
  end

  // End a hung run
  initial begin : watchdog
    #(LIMIT_NS);
    $display("[converter_bringup_sequencer_unit] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/cbs_pkg.sv
design/cbs_ctrl.sv
design/cbs_datapath.sv
design/converter_bringup_sequencer_unit.sv
design/cbs_checker.sv
tb/sv/tb_top.sv
